// ===== hw/rtl/sks_pkg.sv =====
// ----------------------------------------------------------------------------
// sks_pkg
// Types and constants shared by the stable key sorter and its cells.
// ----------------------------------------------------------------------------
package sks_pkg;

    localparam int KEY_BITS      = 32;
    localparam int POS_BITS      = 6;
    localparam int MAX_ITEMS_DEF = 64;

    typedef struct packed {
        logic [KEY_BITS-1:0] sort_key;
        logic                last_in;
    } t_in;

    typedef struct packed {
        logic [KEY_BITS-1:0] out_key;
        logic [POS_BITS-1:0] source_index;
        logic                overflow;
        logic                last_out;
    } t_out;

    // Contents of one cell.
    typedef struct packed {
        logic                valid;
        logic [KEY_BITS-1:0] key;
        logic [POS_BITS-1:0] pos;
    } t_cell;

    // Control broadcast to every cell.
    typedef struct packed {
        logic insert;
        logic drain;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

endpackage

// ===== hw/rtl/sks_cell.sv =====
// ----------------------------------------------------------------------------
// sks_cell
// One slot of the insertion chain: holds a key and its arrival position.
// ----------------------------------------------------------------------------
module sks_cell
    import sks_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_ctl           i_ctl,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [POS_BITS-1:0] i_pos,
    input  t_cell               i_left,
    input  logic                i_left_gt,
    input  t_cell               i_right,
    output t_cell               o_cell,
    output logic                o_gt
);

    logic                r_valid;
    logic [KEY_BITS-1:0] r_key;
    logic [POS_BITS-1:0] r_pos;
    t_cell               n_cell;
    logic                gt;

    // An empty slot counts as greater than any key.
    assign gt = !r_valid || (r_key > i_key);

    always_comb begin
        n_cell = '{valid: r_valid, key: r_key, pos: r_pos};
        if (i_ctl.insert && gt) begin
            // Shift right behind the new key, or take it at the boundary.
            if (i_left_gt) begin
                n_cell = i_left;
            end else begin
                n_cell = '{valid: 1'b1, key: i_key, pos: i_pos};
            end
        end else if (i_ctl.drain) begin
            n_cell = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_cell.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_cell.key;
        r_pos <= n_cell.pos;
    end

    assign o_cell = '{valid: r_valid, key: r_key, pos: r_pos};
    assign o_gt   = gt;

endmodule

// ===== hw/rtl/stable_key_sorter.sv =====
// ----------------------------------------------------------------------------
// stable_key_sorter
// Stable ascending sort of a set of keys on a systolic insertion chain.
// ----------------------------------------------------------------------------
// Usage: drive i_in and raise i_start; a beat is taken at each edge where
// i_start is high and o_busy is low. Keys load one per cycle, each slotted
// into the chain of MAX_ITEMS cells the same cycle, behind every stored key
// less than or equal to it, so equal keys keep arrival order. Keys beyond
// MAX_ITEMS are dropped and the set is marked overflowed.
// The beat with last_in set is still inserted (if room) and then the chain
// drains from its head: o_busy rises the cycle after that beat, and one
// result per stored key follows on o_out with o_strobe high for one cycle,
// the first once the drain state has popped the head into the o_out register,
// then one per cycle. o_busy stays high while stored keys remain; it drops
// while the final result (last_out set) is on the ports, so loading of the
// next set may begin then. Throughput: one key per cycle while loading, one
// result per cycle while draining.
// The receiver cannot stall; results must be taken as they appear.
// Reset empties the chain, clears the count and overflow flag, and idles.
// ----------------------------------------------------------------------------
module stable_key_sorter
    import sks_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_in  i_in,
    output logic o_busy,
    output logic o_strobe,
    output t_out o_out
);

    localparam int CNT_BITS = $clog2(MAX_ITEMS + 1);

    t_state              r_state,  n_state;
    logic [CNT_BITS-1:0] r_count,  n_count;
    logic                r_drop,   n_drop;
    logic                r_strobe, n_strobe;
    t_out                r_out,    n_out;

    t_cell_ctl           ctl;
    logic                accept;
    logic                full;
    t_cell               w_cell [MAX_ITEMS];
    logic                w_gt   [MAX_ITEMS];

    assign accept = i_start && (r_state == ST_LOAD);
    assign full   = (r_count == CNT_BITS'(MAX_ITEMS));

    assign ctl.insert = accept && !full;
    assign ctl.drain  = (r_state == ST_DRAIN);

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        t_cell left_cell;
        logic  left_gt;
        t_cell right_cell;

        if (g == 0) begin : g_head
            // Head sees a valid, not-greater neighbor: the key lands here.
            assign left_cell = '{valid: 1'b1, key: '0, pos: '0};
            assign left_gt   = 1'b0;
        end else begin : g_body
            assign left_cell = w_cell[g-1];
            assign left_gt   = w_gt[g-1];
        end

        if (g == MAX_ITEMS - 1) begin : g_tail
            assign right_cell = '{valid: 1'b0, key: '0, pos: '0};
        end else begin : g_mid
            assign right_cell = w_cell[g+1];
        end

        sks_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl),
            .i_key     (i_in.sort_key),
            .i_pos     (POS_BITS'(r_count)),
            .i_left    (left_cell),
            .i_left_gt (left_gt),
            .i_right   (right_cell),
            .o_cell    (w_cell[g]),
            .o_gt      (w_gt[g])
        );
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_drop   = r_drop;
        n_strobe = 1'b0;
        n_out    = r_out;
        unique case (r_state)
            ST_LOAD: begin
                if (accept) begin
                    if (full) begin
                        n_drop = 1'b1;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                    if (i_in.last_in) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                // Pop the head cell; the chain shifts left in step.
                n_strobe           = 1'b1;
                n_out.out_key      = w_cell[0].key;
                n_out.source_index = w_cell[0].pos;
                n_out.overflow     = r_drop;
                n_out.last_out     = (r_count == CNT_BITS'(1));
                n_count            = r_count - 1'b1;
                if (r_count == CNT_BITS'(1)) begin
                    n_state = ST_LOAD;
                    n_drop  = 1'b0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_count  <= '0;
            r_drop   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_drop   <= n_drop;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_busy   = (r_state == ST_DRAIN);
    assign o_strobe = r_strobe;
    assign o_out    = r_out;

endmodule

// ===== hw/rtl/sks_checker.sv =====
// ----------------------------------------------------------------------------
// sks_checker
// Port-level checks on the drain sequence of the stable key sorter.
// ----------------------------------------------------------------------------
module sks_checker
    import sks_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input t_in  i_in,
    input logic i_busy,
    input logic i_strobe,
    input t_out i_out
);

    // A last_in beat always starts a drain.
    a_last_starts_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !i_busy && i_in.last_in) |=> i_busy)
        else $error("drain did not start after last_in beat");

    // Every busy cycle pops one result.
    a_busy_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_busy |=> i_strobe)
        else $error("busy cycle produced no result");

    // Loading a non-final key yields no result.
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !i_busy && !i_in.last_in) |=> !i_strobe)
        else $error("result appeared while loading");

    // Final result ends the drain; earlier ones keep it going.
    a_last_ends_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_strobe |-> (i_out.last_out == !i_busy))
        else $error("last_out out of step with busy");

    // Overflow flag holds across one set.
    a_overflow_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_strobe && !i_out.last_out) |=> (i_strobe && $stable(i_out.overflow)))
        else $error("overflow changed within a set");

endmodule

bind stable_key_sorter sks_checker u_sks_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .i_in     (i_in),
    .i_busy   (o_busy),
    .i_strobe (o_strobe),
    .i_out    (o_out)
);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Checks the stable key sorter: sets of keys go in one beat at a time; each
// set comes back in ascending key order, ties in arrival order, with source
// index, overflow and last flags matched against a sorted-order model.
// ----------------------------------------------------------------------------
module tb
    import sks_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Sorted-order model and the store of results still due from the sorter.
    class sorted_order_model;
        logic [KEY_BITS-1:0] keys [MAX_ITEMS_DEF];
        logic [POS_BITS-1:0] arrivals [MAX_ITEMS_DEF];
        int unsigned         held;
        bit                  dropped;
        t_out                sorted_due [$];
        int unsigned         mismatches;

        function new();
            held       = 0;
            dropped    = 0;
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return sorted_due.size();
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        task note_key(t_in beat);
            int unsigned slot;
            t_out        r;
            if (held < MAX_ITEMS_DEF) begin
                slot = held;
                // Shift strictly greater keys up; equal keys stay ahead.
                while (slot > 0 && keys[slot-1] > beat.sort_key) begin
                    keys[slot]     = keys[slot-1];
                    arrivals[slot] = arrivals[slot-1];
                    slot--;
                end
                keys[slot]     = beat.sort_key;
                arrivals[slot] = POS_BITS'(held);
                held++;
            end else begin
                dropped = 1'b1;
            end
            if (beat.last_in) begin
                for (int unsigned i = 0; i < held; i++) begin
                    r.out_key      = keys[i];
                    r.source_index = arrivals[i];
                    r.overflow     = dropped;
                    r.last_out     = (i + 1 == held);
                    sorted_due.push_back(r);
                end
                held    = 0;
                dropped = 1'b0;
            end
        endtask

        task check_result(t_out got);
            t_out want;
            if (sorted_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result key %h", got.out_key));
            end else begin
                want = sorted_due.pop_front();
                if (got.out_key !== want.out_key)
                    report_mismatch($sformatf("out_key %h, want %h",
                                              got.out_key, want.out_key));
                if (got.source_index !== want.source_index)
                    report_mismatch($sformatf("source_index %0d, want %0d",
                                              got.source_index, want.source_index));
                if (got.overflow !== want.overflow)
                    report_mismatch($sformatf("overflow %b, want %b",
                                              got.overflow, want.overflow));
                if (got.last_out !== want.last_out)
                    report_mismatch($sformatf("last_out %b, want %b",
                                              got.last_out, want.last_out));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    t_in  i_in;
    logic o_busy;
    logic o_strobe;
    t_out o_out;

    sorted_order_model sorter_model = new();
    bit                gaps_on;
    int unsigned       keys_sent;

    stable_key_sorter #(
        .MAX_ITEMS(MAX_ITEMS_DEF)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_in    (i_in),
        .o_busy  (o_busy),
        .o_strobe(o_strobe),
        .o_out   (o_out)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Note accepted beats before checking results: a set of one may load on
    // the same edge as the previous set's last result.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy)
                sorter_model.note_key(i_in);
            if (o_strobe)
                sorter_model.check_result(o_out);
        end
    end

    task send_key(input logic [KEY_BITS-1:0] key, input logic last);
        if (gaps_on && $urandom_range(0, 99) < 6) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_start        <= 1'b1;
        i_in.sort_key  <= key;
        i_in.last_in   <= last;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        keys_sent++;
    endtask

    // Hold off the next beat until every due result has come out.
    task wait_drained();
        i_start <= 1'b0;
        @(negedge i_clk);
        while (sorter_model.pending() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic [KEY_BITS-1:0] pick_key();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return KEY_BITS'($urandom_range(0, 3));
            2:       return {KEY_BITS{1'b1}} - KEY_BITS'($urandom_range(0, 3));
            default: return $urandom & $urandom;
        endcase
    endfunction

    initial begin
        int unsigned set_no;
        int unsigned set_len;

        i_rst_n   <= 1'b0;
        i_start   <= 1'b0;
        i_in      <= '0;
        gaps_on   = 1'b1;
        keys_sent = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sets of one at both key extremes.
        send_key('0, 1'b1);
        send_key({KEY_BITS{1'b1}}, 1'b1);
        // Extremes out of order.
        send_key({KEY_BITS{1'b1}}, 1'b0);
        send_key('0, 1'b0);
        send_key(KEY_BITS'(7), 1'b1);
        // Ties must keep arrival order.
        send_key(KEY_BITS'(5), 1'b0);
        send_key(KEY_BITS'(5), 1'b0);
        send_key(KEY_BITS'(2), 1'b0);
        send_key(KEY_BITS'(5), 1'b0);
        send_key(KEY_BITS'(2), 1'b1);
        wait_drained();
        // Descending, then ascending, back to back.
        send_key(KEY_BITS'(40), 1'b0);
        send_key(KEY_BITS'(30), 1'b0);
        send_key(KEY_BITS'(20), 1'b0);
        send_key(KEY_BITS'(10), 1'b1);
        send_key(KEY_BITS'(1), 1'b0);
        send_key(KEY_BITS'(2), 1'b0);
        send_key(KEY_BITS'(3), 1'b1);
        send_key(32'hA5A5_5A5A, 1'b1);
        wait_drained();

        // Random sets, mostly short; one fills the chain and overflows
        // (the dropped tail carries last_in).
        set_no = 0;
        while (keys_sent < 100 || set_no < 6) begin
            gaps_on = !(set_no >= 2 && set_no <= 4);
            case (set_no)
                3:       set_len = MAX_ITEMS_DEF + 2;
                default: set_len = $urandom_range(1, 8);
            endcase
            for (int unsigned k = 0; k < set_len; k++)
                send_key(pick_key(), k + 1 == set_len);
            if ($urandom_range(0, 4) == 0)
                wait_drained();
            set_no++;
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sorter_model.mismatches == 0 && sorter_model.pending() == 0) begin
            $display("** stable_key_sorter: PASSED **");
        end else begin
            $display("** stable_key_sorter: FAILED **");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("** stable_key_sorter: FAILED **");
        $finish;
    end

endmodule
